@@ rtl/pnc_pkg.sv @@
// shared types and constants for the palette nearest-color block
// no dependencies; imported by every module of the block
`default_nettype none
package pnc_pkg;

  localparam int unsigned COLOR_W       = 16;
  localparam int unsigned RGB_W         = 3 * COLOR_W;
  localparam int unsigned INDEX_W       = 8;
  localparam int unsigned NUM_W         = 9;
  localparam int unsigned DIST_W        = 18;
  localparam int unsigned DEPTH_DEFAULT = 256;
  localparam int unsigned MEM_MAX       = 256;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned IN_DATA_W     = 56;
  localparam int unsigned OUT_DATA_W    = 56;
  localparam int unsigned MODE_W        = 2;

  localparam logic [NUM_W-1:0] NUM_RESET = 9'd256;

  // request mode codes
  localparam logic [MODE_W-1:0] MODE_MAP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  typedef enum logic [2:0] {
    OP_MAP,
    OP_WRITE,
    OP_READ,
    OP_ERR,
    OP_NOP
  } op_t;

  // color packed red in the low bits, then green, then blue
  typedef struct packed {
    op_t                op;
    logic [INDEX_W-1:0] index;
    logic [RGB_W-1:0]   color;
    logic [NUM_W-1:0]   count;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/pnc_front.sv @@
// front end: accepts requests, holds the color count register and
// classifies each request into a command; uses pnc_pkg
`default_nettype none
module pnc_front
  import pnc_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [MODE_W-1:0]     in_tuser,
  input  wire logic                  cfg_we,
  input  wire logic [NUM_W-1:0]      cfg_wdata,
  input  wire logic                  q_full,
  output logic                       q_push,
  output cmd_t                       q_cmd
);

  logic [NUM_W-1:0]   num_colors_r;
  logic [NUM_W-1:0]   usable;
  logic [INDEX_W-1:0] idx;
  logic               in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_colors_r <= NUM_RESET;
    end else if (cfg_we) begin
      num_colors_r <= cfg_wdata;
    end
  end

  assign usable    = (32'(num_colors_r) < PALETTE_DEPTH) ? num_colors_r
                                                         : NUM_W'(PALETTE_DEPTH);
  assign idx       = in_tdata[INDEX_W-1:0];
  assign in_range  = {1'b0, idx} < usable;
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_cmd.index = idx;
    q_cmd.color = in_tdata[INDEX_W +: RGB_W];
    q_cmd.count = usable;
    case (in_tuser)
      MODE_MAP:   q_cmd.op = OP_MAP;
      MODE_WRITE: q_cmd.op = in_range ? OP_WRITE : OP_ERR;
      MODE_READ:  q_cmd.op = in_range ? OP_READ : OP_ERR;
      default:    q_cmd.op = OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/pnc_queue.sv @@
// short command queue between the front end and the execution unit
// uses pnc_pkg for the command type and depth
`default_nettype none
module pnc_queue
  import pnc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      full,
  output logic      empty
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   fill_r;

  assign full  = fill_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty = fill_r == '0;
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/pnc_back.sv @@
// execution unit: palette memory, last-match cache, nearest-entry scan
// and the result register; uses pnc_pkg
`default_nettype none
module pnc_back
  import pnc_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_empty,
  input  cmd_t                       q_head,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tuser
);

  // only indexes below 256 can be written, higher entries stay zero
  localparam int unsigned MEM_DEPTH = (PALETTE_DEPTH < MEM_MAX) ? PALETTE_DEPTH : MEM_MAX;
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_SCAN,
    S_DONE
  } state_t;

  state_t              state_r;
  cmd_t                cmd_r;

  logic [RGB_W-1:0]    mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_r;
  logic [RGB_W-1:0]    rd_data_r;
  logic                rd_vld_r;
  logic [RGB_W-1:0]    rd_q;
  logic [MEM_AW-1:0]   rd_addr;
  logic                rd_in_mem;
  logic                wr_en;

  logic [RGB_W-1:0]    cached_color_r;
  logic [INDEX_W-1:0]  cached_idx_r;

  logic [NUM_W-1:0]    iss_r;
  logic                issue;
  logic                p1_v_r;
  logic [NUM_W-1:0]    p1_i_r;
  logic                p2_v_r;
  logic [NUM_W-1:0]    p2_i_r;
  logic [DIST_W-1:0]   d_r;
  logic [DIST_W-1:0]   cur_dist;
  logic [NUM_W-1:0]    best_i_r;
  logic [DIST_W-1:0]   best_d_r;

  logic [INDEX_W-1:0]  res_pix_r;
  logic [RGB_W-1:0]    res_col_r;
  logic                res_err_r;
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                out_tuser_r;

  function automatic logic [COLOR_W-1:0] absd(input logic [COLOR_W-1:0] a,
                                               input logic [COLOR_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  assign issue = iss_r < cmd_r.count;
  assign q_pop = (state_r == S_IDLE) && !q_empty;
  assign rd_q  = rd_vld_r ? rd_data_r : '0;

  assign cur_dist = DIST_W'(absd(rd_q[0 +: COLOR_W], cmd_r.color[0 +: COLOR_W]))
                  + DIST_W'(absd(rd_q[COLOR_W +: COLOR_W], cmd_r.color[COLOR_W +: COLOR_W]))
                  + DIST_W'(absd(rd_q[2*COLOR_W +: COLOR_W],
                                 cmd_r.color[2*COLOR_W +: COLOR_W]));

  // memory port control
  always_comb begin
    rd_addr   = '0;
    rd_in_mem = 1'b0;
    wr_en     = 1'b0;
    case (state_r)
      S_RD: begin
        if (cmd_r.op == OP_MAP) begin
          rd_addr   = cached_idx_r[MEM_AW-1:0];
          rd_in_mem = 1'b1;
        end else if (cmd_r.op == OP_READ) begin
          rd_addr   = cmd_r.index[MEM_AW-1:0];
          rd_in_mem = 1'b1;
        end else if (cmd_r.op == OP_WRITE) begin
          wr_en = 1'b1;
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_addr   = iss_r[MEM_AW-1:0];
          rd_in_mem = 32'(iss_r) < MEM_DEPTH;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cmd_r.index[MEM_AW-1:0]] <= cmd_r.color;
    end
    rd_data_r <= mem[rd_addr];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[cmd_r.index[MEM_AW-1:0]] <= 1'b1;
      end
      rd_vld_r <= rd_in_mem && vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      cached_color_r <= '0;
      cached_idx_r   <= '0;
      p1_v_r         <= 1'b0;
      p2_v_r         <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r     <= q_head;
            res_pix_r <= '0;
            res_col_r <= '0;
            res_err_r <= q_head.op == OP_ERR;
            if (q_head.op == OP_MAP || q_head.op == OP_READ || q_head.op == OP_WRITE) begin
              state_r <= S_RD;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_RD: begin
          state_r <= (cmd_r.op == OP_WRITE) ? S_DONE : S_CHK;
        end
        S_CHK: begin
          if (cmd_r.op == OP_READ) begin
            res_col_r <= rd_q;
            state_r   <= S_DONE;
          end else if (cached_color_r == cmd_r.color && rd_q == cmd_r.color) begin
            res_pix_r <= cached_idx_r;
            state_r   <= S_DONE;
          end else begin
            iss_r    <= '0;
            best_i_r <= '0;
            best_d_r <= '1;
            p1_v_r   <= 1'b0;
            p2_v_r   <= 1'b0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          // read, distance, compare: three stages in flight
          p1_v_r <= issue;
          p1_i_r <= iss_r;
          if (issue) begin
            iss_r <= iss_r + 1'b1;
          end
          p2_v_r <= p1_v_r;
          p2_i_r <= p1_i_r;
          d_r    <= cur_dist;
          if (p2_v_r && d_r < best_d_r) begin
            best_i_r <= p2_i_r;
            best_d_r <= d_r;
          end
          if (p2_v_r && d_r == '0) begin
            res_pix_r      <= INDEX_W'(p2_i_r);
            cached_color_r <= cmd_r.color;
            cached_idx_r   <= INDEX_W'(p2_i_r);
            state_r        <= S_DONE;
          end else if (!issue && !p1_v_r && !p2_v_r) begin
            res_pix_r <= INDEX_W'(best_i_r);
            state_r   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_tdata_r <= {res_col_r, res_pix_r};
            out_tuser_r <= res_err_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
`default_nettype wire

@@ rtl/palette_nearest_color.sv @@
// top level of the palette nearest-color block: front end, command queue
// and execution unit; uses pnc_pkg, pnc_front, pnc_queue, pnc_back
//
// channel  dir  bits (lowest first)
// in_*     in   tdata: index[7:0] red[23:8] green[39:24] blue[55:40]; tuser: mode[1:0]
// out_*    out  tdata: pixel[7:0] red[23:8] green[39:24] blue[55:40]; tuser: error
// cfg_*    in   wdata: num_colors[8:0], written when cfg_we is high
//
// error and unused-mode requests go from S_IDLE straight to S_DONE, write passes S_RD,
// read passes S_RD and S_CHK; map passes S_RD and S_CHK, ends there on a cache hit and
// else scans the usable entries through the single memory read port, stopping at an
// exact match; an empty palette has none to scan; a stalled result waits on out_tready
// a two-entry queue lets requests enter while the execution unit works or the result waits
// reset is synchronous; palette entries read as zero until written, no clearing pass
`default_nettype none
module palette_nearest_color
  import pnc_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // index, red, green, blue
  input  wire logic [MODE_W-1:0]     in_tuser,   // mode
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // pixel, red, green, blue
  output logic                       out_tuser,  // error
  input  wire logic                  cfg_we,
  input  wire logic [NUM_W-1:0]      cfg_wdata   // num_colors
);

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_cmd;
  cmd_t q_head;

  pnc_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  pnc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  pnc_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

@@ rtl/pnc_checker.sv @@
// port-level checks for palette_nearest_color, attached by bind
// uses pnc_pkg for port widths
`default_nettype none
module pnc_port_checks
  import pnc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tuser
);

  // result channel empty right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a refused request keeps all payload fields zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error result carries nonzero data");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind palette_nearest_color pnc_port_checks u_pnc_checker (.*);
`default_nettype wire

@@ sim/pnc_checker.sv @@
// checker for palette_nearest_color: watches the request, result and count channels,
// predicts every result from its own copy of the palette and cache, compares field by field
// depends on pnc_pkg only
module pnc_checker
  import pnc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // index, red, green, blue
  input  wire logic [MODE_W-1:0]     in_tuser,   // mode
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,  // pixel, red, green, blue
  input  wire logic                  out_tuser,  // error
  input  wire logic                  cfg_we,
  input  wire logic [NUM_W-1:0]      cfg_wdata,  // num_colors
  output int                         mismatches,
  output int                         outstanding,
  output int                         checked,
  output int                         cache_hits,
  output int                         bound_errors
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [INDEX_W-1:0] pixel;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               error;
  } answer_t;

  // colors packed red low, then green, then blue
  logic [RGB_W-1:0]   palette_q [MEM_MAX];
  logic [RGB_W-1:0]   hit_color;
  logic [INDEX_W-1:0] hit_index;
  logic [NUM_W-1:0]   color_count;
  answer_t            answers_q [$];
  answer_t            oldest;

  function automatic answer_t predict_answer(input logic [MODE_W-1:0]  mode,
                                             input logic [INDEX_W-1:0] idx,
                                             input logic [RGB_W-1:0]   rgb);
    answer_t            ans;
    int unsigned        usable;
    int unsigned        sum_dist;
    int unsigned        best_dist;
    logic [INDEX_W-1:0] best;
    logic [COLOR_W-1:0] a;
    logic [COLOR_W-1:0] b;
    ans = '0;
    usable = (color_count < MEM_MAX) ? color_count : MEM_MAX;
    if (mode == MODE_MAP) begin
      // the cache wins over the scan and does not look at the count
      if (hit_color == rgb && palette_q[hit_index] == rgb) begin
        ans.pixel = hit_index;
        cache_hits++;
      end else begin
        best = '0;
        best_dist = 32'h8000_0000;
        for (int i = 0; i < usable; i++) begin
          sum_dist = 0;
          for (int c = 0; c < 3; c++) begin
            a = rgb[c*COLOR_W +: COLOR_W];
            b = palette_q[i][c*COLOR_W +: COLOR_W];
            sum_dist += (a > b) ? a - b : b - a;
          end
          // strict compare keeps the lowest index on a tie
          if (sum_dist < best_dist) begin
            best = INDEX_W'(i);
            if (sum_dist == 0) begin
              hit_color = rgb;
              hit_index = INDEX_W'(i);
              break;
            end
            best_dist = sum_dist;
          end
        end
        ans.pixel = best;
      end
    end else if (mode == MODE_WRITE || mode == MODE_READ) begin
      if (idx >= usable) begin
        ans.error = 1'b1;
        bound_errors++;
      end else if (mode == MODE_WRITE) begin
        palette_q[idx] = rgb;
      end else begin
        {ans.blue, ans.green, ans.red} = palette_q[idx];
      end
    end
    return ans;
  endfunction

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (palette_q[i]) palette_q[i] = '0;
      hit_color = '0;
      hit_index = '0;
      color_count = NUM_RESET;
      answers_q.delete();
    end else begin
      // a result leaving now always belongs to an earlier request
      if (out_tvalid && out_tready) begin
        if (answers_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result 0x%0h/%0b with no request pending", $time, out_tdata,
                     out_tuser);
        end else begin
          oldest = answers_q.pop_front();
          checked++;
          compare_field("pixel", oldest.pixel, out_tdata[INDEX_W-1:0]);
          compare_field("red", oldest.red, out_tdata[INDEX_W +: COLOR_W]);
          compare_field("green", oldest.green, out_tdata[INDEX_W+COLOR_W +: COLOR_W]);
          compare_field("blue", oldest.blue, out_tdata[INDEX_W+2*COLOR_W +: COLOR_W]);
          compare_field("error", oldest.error, out_tuser);
        end
      end
      if (cfg_we) color_count = cfg_wdata;
      if (in_tvalid && in_tready)
        answers_q.push_back(predict_answer(in_tuser, in_tdata[INDEX_W-1:0],
                                           in_tdata[INDEX_W +: RGB_W]));
    end
    outstanding = answers_q.size();
  end

endmodule

@@ sim/tb_palette_nearest_color.sv @@
// top of the palette_nearest_color testbench: clock, reset, request and count stimulus,
// random result back-pressure and the verdict; depends on pnc_pkg, pnc_checker and the block
module tb_palette_nearest_color;
  timeunit 1ns;
  timeprecision 1ps;
  import pnc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // index, red, green, blue
  logic [MODE_W-1:0]     in_tuser;   // mode
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // pixel, red, green, blue
  logic                  out_tuser;  // error
  logic                  cfg_we;
  logic [NUM_W-1:0]      cfg_wdata;  // num_colors

  int mismatches;
  int outstanding;
  int checked;
  int cache_hits;
  int bound_errors;
  int src_idle_pct;
  int sink_idle_pct;
  int sent;

  logic [RGB_W-1:0] tone_pool [$];

  palette_nearest_color i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  pnc_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .checked      (checked),
    .cache_hits   (cache_hits),
    .bound_errors (bound_errors)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= sink_idle_pct);

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic push_request(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] idx,
                              input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                              input logic [COLOR_W-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r, idx};
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    sent++;
    @(negedge clk);
  endtask

  task automatic set_color_count(input int unsigned count);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= NUM_W'(count);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_request(input int unsigned usable);
    int unsigned        pick;
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] idx;
    logic [RGB_W-1:0]   rgb;
    pick = $urandom_range(99);
    if (pick < 45) mode = MODE_MAP;
    else if (pick < 75) mode = MODE_WRITE;
    else if (pick < 95) mode = MODE_READ;
    else mode = MODE_UNUSED;
    if (usable > 0 && $urandom_range(9) < 8) idx = INDEX_W'($urandom_range(usable - 1));
    else idx = INDEX_W'($urandom_range(255));
    // reuse of known colors gives exact matches, duplicates and cache hits
    pick = $urandom_range(3);
    if (tone_pool.size() == 0 && (pick == 1 || pick == 2)) pick = 0;
    case (pick)
      0: rgb = {16'($urandom), 16'($urandom), 16'($urandom)};
      1: rgb = tone_pool[$urandom_range(tone_pool.size() - 1)];
      2: rgb = tone_pool[$urandom_range(tone_pool.size() - 1)] ^
               {16'($urandom_range(3)), 16'($urandom_range(3)), 16'($urandom_range(3))};
      default: rgb = {16'($urandom_range(15)), 16'($urandom_range(15)),
                      16'($urandom_range(15))};
    endcase
    if (mode == MODE_WRITE) begin
      tone_pool.push_back(rgb);
      if (tone_pool.size() > 24) void'(tone_pool.pop_front());
    end
    push_request(mode, idx, rgb[COLOR_W-1:0], rgb[COLOR_W +: COLOR_W],
                 rgb[2*COLOR_W +: COLOR_W]);
  endtask

  initial begin
    int unsigned seg_counts [6];
    int unsigned count;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sent = 0;
    src_idle_pct = 21;
    sink_idle_pct = 68;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // full palette after reset, all entries zero
    push_request(MODE_MAP, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    push_request(MODE_WRITE, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_request(MODE_WRITE, 8'hFF, 16'h1234, 16'h5678, 16'h9ABC);
    push_request(MODE_READ, 8'hFF, 16'h0000, 16'h0000, 16'h0000);
    push_request(MODE_READ, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    push_request(MODE_MAP, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_request(MODE_MAP, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // entry changes under the cache, so the cached color must be rescanned
    push_request(MODE_WRITE, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFE);
    push_request(MODE_MAP, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // tie between entries 1 and 2, lowest index wins
    push_request(MODE_WRITE, 8'h02, 16'h0002, 16'h0000, 16'h0000);
    push_request(MODE_MAP, 8'h00, 16'h0001, 16'h0000, 16'h0000);
    // cached entry 5 beats an identical lower entry 4
    push_request(MODE_WRITE, 8'h05, 16'h0007, 16'h0007, 16'h0007);
    push_request(MODE_MAP, 8'h00, 16'h0007, 16'h0007, 16'h0007);
    push_request(MODE_WRITE, 8'h04, 16'h0007, 16'h0007, 16'h0007);
    push_request(MODE_MAP, 8'h00, 16'h0007, 16'h0007, 16'h0007);
    push_request(MODE_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

    set_color_count(2);
    push_request(MODE_WRITE, 8'h02, 16'h1111, 16'h2222, 16'h3333);
    push_request(MODE_READ, 8'h01, 16'h0000, 16'h0000, 16'h0000);
    push_request(MODE_READ, 8'hFF, 16'h0000, 16'h0000, 16'h0000);
    push_request(MODE_WRITE, 8'h00, 16'h0000, 16'h0000, 16'h0000);

    // single entry at zero against the far corner: largest distance
    set_color_count(1);
    push_request(MODE_MAP, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);

    // empty palette: cache still answers, otherwise index 0
    set_color_count(0);
    push_request(MODE_MAP, 8'h00, 16'h0007, 16'h0007, 16'h0007);
    push_request(MODE_MAP, 8'h00, 16'h0100, 16'h0000, 16'h0000);
    push_request(MODE_WRITE, 8'h00, 16'hFFFF, 16'h0000, 16'hFFFF);
    push_request(MODE_READ, 8'h03, 16'h0000, 16'h0000, 16'h0000);

    // count above the depth is clipped to it
    set_color_count(511);
    push_request(MODE_WRITE, 8'hFF, 16'hABCD, 16'h0F0F, 16'hF0F0);
    push_request(MODE_READ, 8'hFF, 16'h0000, 16'h0000, 16'h0000);

    seg_counts = '{24, 1, 256, 0, 511, $urandom_range(2, 64)};
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        src_idle_pct = 68;
        sink_idle_pct = 21;
      end else if (seg == 4) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      count = seg_counts[seg];
      set_color_count(count);
      repeat (130) random_request((count < MEM_MAX) ? count : MEM_MAX);
    end

    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("%0d requests sent, %0d results checked, %0d answered from the cache",
             sent, checked, cache_hits);
    $display("%0d out-of-range accesses, color counts 0, 1, 2, 24, 256 and 511 among others",
             bound_errors);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_palette_nearest_color passed");
    end else begin
      $display("tb_palette_nearest_color failed");
    end
    $finish;
  end

  initial begin
    #25ms;
    $display("timeout with %0d results outstanding", outstanding);
    $display("tb_palette_nearest_color failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pnc_pkg.sv
rtl/pnc_front.sv
rtl/pnc_queue.sv
rtl/pnc_back.sv
rtl/palette_nearest_color.sv
rtl/pnc_checker.sv
sim/pnc_checker.sv
sim/tb_palette_nearest_color.sv
